// File: src/rtt_pkg.sv
`timescale 1ns / 1ps

package rtt_pkg;

  localparam int NUMBER_BITS_DEF = 32;
  localparam int RADIX_W         = 6;
  localparam int CHAR_W          = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_MINUS       = 7'h2D;
  localparam logic [CHAR_W-1:0] CHAR_NUL         = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO        = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LETTER_BASE = 7'h57;

  // Quotient bits resolved per cycle by the digit divider.
  localparam int DIV_STEPS = 8;

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last;
  } out_item_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < 6'd10) begin
      ch = CHAR_ZERO + {1'b0, d};
    end else begin
      ch = CHAR_LETTER_BASE + {1'b0, d};
    end
    return ch;
  endfunction

endpackage

// File: src/radix_integer_to_text_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_push / in_full    in_number (signed)
// result    out        out_pop / out_empty  out_text_char, out_last
// config    in         cfg_we               cfg_radix
//
// Each digit is found by the divider (8 quotient bits per cycle) and stored in the
// digit RAM; the digits are then read back from the RAM, after a minus sign for a
// negative number.
// A bad radix gives only the terminator.
// Reset is synchronous and clears the queues and the radix (to 10).
// A full result queue stalls the back end; two queued inputs let the front run ahead.

module radix_integer_to_text_unit
  import rtt_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic signed [NUMBER_BITS-1:0] in_number,
  output logic                          in_full,
  output logic [CHAR_W-1:0]             out_text_char,
  output logic                          out_last,
  output logic                          out_empty,
  input  logic                          out_pop,
  input  logic                          cfg_we,
  input  logic [RADIX_W-1:0]            cfg_radix
);

  logic [RADIX_W-1:0]           radix_r;
  logic                         cmd_empty;
  logic                         cmd_pop;
  logic [NUMBER_BITS+RADIX_W+1:0] cmd_data;
  out_item_t                    out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_radix;
    end
  end

  rtt_front #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_number (in_number),
    .in_full   (in_full),
    .radix     (radix_r),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop)
  );

  rtt_back #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  assign out_text_char = out_item.text_char;
  assign out_last      = out_item.last;

endmodule

// File: src/rtt_fifo.sv
`timescale 1ns / 1ps

module rtt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: src/rtt_ram.sv
`timescale 1ns / 1ps

module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

// File: src/rtt_front.sv
`timescale 1ns / 1ps

module rtt_front
  import rtt_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  logic signed [NUMBER_BITS-1:0]      in_number,
  output logic                               in_full,
  input  logic [RADIX_W-1:0]                 radix,
  output logic                               cmd_empty,
  output logic [NUMBER_BITS+RADIX_W+1:0]     cmd_data,
  input  logic                               cmd_pop
);

  localparam int ENTRY_W = NUMBER_BITS + RADIX_W + 2;

  logic                   negative;
  logic [NUMBER_BITS-1:0] magnitude;
  logic                   base_ok;
  logic [ENTRY_W-1:0]     entry;
  logic                   full;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

  // Negating the most negative value wraps to itself, which read unsigned is
  // exactly its magnitude.
  assign negative  = in_number[NUMBER_BITS-1];
  assign magnitude = negative ? (~in_number + 1'b1) : in_number;
  assign base_ok   = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign entry     = {negative, base_ok, radix, magnitude};
  assign in_full   = full;

  rtt_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (entry),
    .pop   (cmd_pop),
    .rdata (cmd_data),
    .empty (cmd_empty),
    .full  (full),
    .count (cmd_count)
  );

endmodule

// File: src/rtt_back.sv
`timescale 1ns / 1ps

module rtt_back
  import rtt_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_empty,
  input  logic [NUMBER_BITS+RADIX_W+1:0] cmd_data,
  output logic                           cmd_pop,
  output out_item_t                      out_item,
  output logic                           out_empty,
  input  logic                           out_pop
);

  localparam int CNT_W = $clog2(NUMBER_BITS + 1);
  localparam int IDX_W = $clog2(NUMBER_BITS);
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_NUL  = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [NUMBER_BITS-1:0] quot_r, quot_nxt;
  logic [RADIX_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]       bits_r, bits_nxt;
  logic [CNT_W-1:0]       ndig_r, ndig_nxt;
  logic                   neg_r, neg_nxt;
  logic [RADIX_W-1:0]     base_r, base_nxt;
  logic                   rd_pend_r, rd_pend_nxt;

  logic [NUMBER_BITS-1:0] div_w;
  logic [RADIX_W-1:0]     div_r;
  logic [RADIX_W:0]       div_t;
  logic                   div_last;
  logic [CNT_W-1:0]       ndig_dec;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_raddr;
  logic [RADIX_W-1:0]     ram_rdata;

  logic                   push;
  out_item_t              push_item;
  logic                   out_full;
  logic [OCW-1:0]         out_count;
  logic                   room;

  // Front-end entry fields.
  logic                   c_neg;
  logic                   c_base_ok;
  logic [RADIX_W-1:0]     c_base;
  logic [NUMBER_BITS-1:0] c_mag;

  assign {c_neg, c_base_ok, c_base, c_mag} = cmd_data;

  // Restoring division, several quotient bits per cycle. The partial
  // remainder stays below the base, so it never needs more than 6 bits.
  always_comb begin
    div_w = quot_r;
    div_r = rem_r;
    div_t = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (bits_r > CNT_W'(k)) begin
        div_t = {div_r, div_w[NUMBER_BITS-1]};
        div_w = {div_w[NUMBER_BITS-2:0], 1'b0};
        if (div_t >= {1'b0, base_r}) begin
          div_t    = div_t - {1'b0, base_r};
          div_w[0] = 1'b1;
        end
        div_r = div_t[RADIX_W-1:0];
      end
    end
  end

  assign div_last  = (bits_r <= CNT_W'(DIV_STEPS));
  assign ndig_dec  = ndig_r - 1'b1;
  assign ram_raddr = ndig_dec[IDX_W-1:0];
  // A read issued now lands in the queue next cycle, behind any read in flight.
  assign room      = (out_count + OCW'(rd_pend_r)) < OCW'(OUT_DEPTH);

  always_comb begin
    state_nxt   = state_r;
    quot_nxt    = quot_r;
    rem_nxt     = rem_r;
    bits_nxt    = bits_r;
    ndig_nxt    = ndig_r;
    neg_nxt     = neg_r;
    base_nxt    = base_r;
    rd_pend_nxt = 1'b0;
    ram_we      = 1'b0;
    cmd_pop     = 1'b0;
    push        = 1'b0;
    push_item   = '{text_char: CHAR_NUL, last: 1'b0};

    if (rd_pend_r) begin
      push      = 1'b1;
      push_item = '{text_char: digit_char(ram_rdata), last: 1'b0};
    end

    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          quot_nxt = c_mag;
          rem_nxt  = '0;
          bits_nxt = CNT_W'(NUMBER_BITS);
          ndig_nxt = '0;
          neg_nxt  = c_neg;
          base_nxt = c_base;
          state_nxt = c_base_ok ? ST_DIV : ST_NUL;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          ram_we   = 1'b1;
          ndig_nxt = ndig_r + 1'b1;
          quot_nxt = div_w;
          rem_nxt  = '0;
          bits_nxt = CNT_W'(NUMBER_BITS);
          if (div_w == '0) begin
            state_nxt = neg_r ? ST_SIGN : ST_EMIT;
          end
        end else begin
          quot_nxt = div_w;
          rem_nxt  = div_r;
          bits_nxt = bits_r - CNT_W'(DIV_STEPS);
        end
      end
      ST_SIGN: begin
        if (!out_full) begin
          push      = 1'b1;
          push_item = '{text_char: CHAR_MINUS, last: 1'b0};
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Digits were stored least significant first; read them back down.
        if (ndig_r == '0) begin
          state_nxt = ST_NUL;
        end else if (room) begin
          rd_pend_nxt = 1'b1;
          ndig_nxt    = ndig_dec;
        end
      end
      ST_NUL: begin
        if (!rd_pend_r && !out_full) begin
          push      = 1'b1;
          push_item = '{text_char: CHAR_NUL, last: 1'b1};
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    bits_r <= bits_nxt;
    ndig_r <= ndig_nxt;
    neg_r  <= neg_nxt;
    base_r <= base_nxt;
  end

  rtt_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (NUMBER_BITS)
  ) u_digit_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ndig_r[IDX_W-1:0]),
    .wdata (div_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rtt_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_item),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty),
    .full  (out_full),
    .count (out_count)
  );

endmodule
